// File: rtl/core/tplp_pkg.sv
// ---------------------------------------------------------------------------
// tplp_pkg: shared types and constants of the two-point line core
// Field widths, iteration counts and the record that travels through the
// divide / square-root pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package tplp_pkg;

   // Field widths
   localparam int CoordW   = 16;            // Q8.8 coordinate
   localparam int SumW     = CoordW + 1;    // midpoint sum, Q9.8
   localparam int DiffW    = CoordW + 1;    // exact coordinate difference
   localparam int SlopeW   = 33;            // Q17.16 slope
   localparam int SpanW    = 17;            // square root result
   localparam int IcptW    = 40;            // Q24.16 intercept
   localparam int ProdW    = SlopeW + CoordW;

   // Divider: dividend |dy| << 16, divisor |dx|
   localparam int FracBits  = 16;
   localparam int DivW      = 2 * SpanW;    // dividend / quotient accumulator
   localparam int DivRemW   = DiffW;        // partial remainder and divisor
   localparam int DivBitsPerStage = DivW / SpanW;

   // Square root: radicand dx*dx + dy*dy
   localparam int RadW      = 2 * DiffW;
   localparam int SqrtRemW  = SpanW + 1;

   // One iteration stage per root bit; the divider retires two bits each
   localparam int IterStages = SpanW;

   // Intercept arithmetic
   localparam int IcptShift = 8;
   localparam int IcptCalcW = IcptW + 2;

   // Item record inside the iteration pipeline
   typedef struct packed {
      logic                     vertical;
      logic                     neg;
      logic [DivW-1:0]          div_acc;
      logic [DivRemW-1:0]       div_rem;
      logic [DivRemW-1:0]       div_dvs;
      logic [RadW-1:0]          sq_rad;
      logic [SqrtRemW-1:0]      sq_rem;
      logic [SpanW-1:0]         sq_root;
      logic signed [SumW-1:0]   mid_x;
      logic signed [SumW-1:0]   mid_y;
      logic signed [CoordW-1:0] x1;
      logic signed [CoordW-1:0] y1;
   } tplp_iter_type;

endpackage

`default_nettype wire

// File: rtl/core/tplp_prep.sv
// ---------------------------------------------------------------------------
// tplp_prep: front stages of the two-point line core
// Forms differences and sums, then magnitudes and squares, then the
// radicand, and loads the record for the iteration stages.
// ---------------------------------------------------------------------------
`default_nettype none

module tplp_prep (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              advance,
   input  wire logic                              in_valid,
   input  wire logic signed [tplp_pkg::CoordW-1:0] first_x,
   input  wire logic signed [tplp_pkg::CoordW-1:0] first_y,
   input  wire logic signed [tplp_pkg::CoordW-1:0] second_x,
   input  wire logic signed [tplp_pkg::CoordW-1:0] second_y,
   output logic                                   out_valid,
   output tplp_pkg::tplp_iter_type                out_data
);
   import tplp_pkg::*;

   // Stage 1 registers
   logic                     s1_valid_ff;
   logic signed [DiffW-1:0]  s1_dx_ff, s1_dy_ff;
   logic signed [SumW-1:0]   s1_midx_ff, s1_midy_ff;
   logic signed [CoordW-1:0] s1_x1_ff, s1_y1_ff;

   // Stage 2 registers
   logic                     s2_valid_ff;
   logic                     s2_vert_ff, s2_neg_ff;
   logic [DivRemW-1:0]       s2_adx_ff, s2_ady_ff;
   logic [RadW-1:0]          s2_sqx_ff, s2_sqy_ff;
   logic signed [SumW-1:0]   s2_midx_ff, s2_midy_ff;
   logic signed [CoordW-1:0] s2_x1_ff, s2_y1_ff;

   // Stage 3 registers
   logic                     s3_valid_ff;
   tplp_iter_type            s3_data_ff;
   tplp_iter_type            s3_data_in;

   // Stage 2 combinational terms
   logic signed [RadW-1:0]   sqx_in, sqy_in;
   logic [DivRemW-1:0]       adx_in, ady_in;

   assign sqx_in = RadW'(s1_dx_ff) * RadW'(s1_dx_ff);
   assign sqy_in = RadW'(s1_dy_ff) * RadW'(s1_dy_ff);
   assign adx_in = s1_dx_ff[DiffW-1] ? DivRemW'(-s1_dx_ff) : DivRemW'(s1_dx_ff);
   assign ady_in = s1_dy_ff[DiffW-1] ? DivRemW'(-s1_dy_ff) : DivRemW'(s1_dy_ff);

   // Load the iteration record
   always_comb begin
      s3_data_in          = '0;
      s3_data_in.vertical = s2_vert_ff;
      s3_data_in.neg      = s2_neg_ff;
      s3_data_in.div_acc  = DivW'({s2_ady_ff, {FracBits{1'b0}}});
      s3_data_in.div_rem  = '0;
      s3_data_in.div_dvs  = s2_adx_ff;
      s3_data_in.sq_rad   = s2_sqx_ff + s2_sqy_ff;
      s3_data_in.sq_rem   = '0;
      s3_data_in.sq_root  = '0;
      s3_data_in.mid_x    = s2_midx_ff;
      s3_data_in.mid_y    = s2_midy_ff;
      s3_data_in.x1       = s2_x1_ff;
      s3_data_in.y1       = s2_y1_ff;
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_dx_ff   <= DiffW'(second_x) - DiffW'(first_x);
         s1_dy_ff   <= DiffW'(second_y) - DiffW'(first_y);
         s1_midx_ff <= SumW'(first_x) + SumW'(second_x);
         s1_midy_ff <= SumW'(first_y) + SumW'(second_y);
         s1_x1_ff   <= first_x;
         s1_y1_ff   <= first_y;

         s2_vert_ff <= (s1_dx_ff == '0);
         s2_neg_ff  <= s1_dx_ff[DiffW-1] ^ s1_dy_ff[DiffW-1];
         s2_adx_ff  <= adx_in;
         s2_ady_ff  <= ady_in;
         s2_sqx_ff  <= RadW'(sqx_in);
         s2_sqy_ff  <= RadW'(sqy_in);
         s2_midx_ff <= s1_midx_ff;
         s2_midy_ff <= s1_midy_ff;
         s2_x1_ff   <= s1_x1_ff;
         s2_y1_ff   <= s1_y1_ff;

         s3_data_ff <= s3_data_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_data  = s3_data_ff;

endmodule

`default_nettype wire

// File: rtl/core/tplp_iter.sv
// ---------------------------------------------------------------------------
// tplp_iter: one iteration stage of the two-point line core
// Retires two quotient bits of the restoring divider and one root bit of
// the digit-by-digit square root, then registers the record.
// ---------------------------------------------------------------------------
`default_nettype none

module tplp_iter (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    advance,
   input  wire logic                    in_valid,
   input  wire tplp_pkg::tplp_iter_type in_data,
   output logic                         out_valid,
   output tplp_pkg::tplp_iter_type      out_data
);
   import tplp_pkg::*;

   logic                  valid_ff;
   tplp_iter_type         data_ff;
   tplp_iter_type         data_in;
   logic [DivRemW:0]      div_trial;
   logic [SqrtRemW+1:0]   sq_cur;
   logic [SqrtRemW+1:0]   sq_try;

   // Divide and root steps
   always_comb begin
      data_in   = in_data;
      div_trial = '0;
      for (int k = 0; k < DivBitsPerStage; k++) begin
         div_trial       = {data_in.div_rem, data_in.div_acc[DivW-1]};
         data_in.div_acc = {data_in.div_acc[DivW-2:0], 1'b0};
         if (div_trial >= {1'b0, data_in.div_dvs}) begin
            data_in.div_rem    = DivRemW'(div_trial - {1'b0, data_in.div_dvs});
            data_in.div_acc[0] = 1'b1;
         end else begin
            data_in.div_rem = div_trial[DivRemW-1:0];
         end
      end

      sq_cur         = {data_in.sq_rem, data_in.sq_rad[RadW-1 -: 2]};
      sq_try         = (SqrtRemW+2)'({data_in.sq_root, 2'b01});
      data_in.sq_rad = {data_in.sq_rad[RadW-3:0], 2'b00};
      if (sq_cur >= sq_try) begin
         data_in.sq_rem  = SqrtRemW'(sq_cur - sq_try);
         data_in.sq_root = {data_in.sq_root[SpanW-2:0], 1'b1};
      end else begin
         data_in.sq_rem  = sq_cur[SqrtRemW-1:0];
         data_in.sq_root = {data_in.sq_root[SpanW-2:0], 1'b0};
      end
   end

   // Advance valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // Partial remainder stays below the divisor on every live non-vertical item
   a_div_rem_bound: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !data_ff.vertical |-> data_ff.div_rem < data_ff.div_dvs)
      else $error("divider remainder not below divisor");

   // Root remainder never exceeds twice the partial root
   a_sqrt_rem_bound: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> data_ff.sq_rem <= {data_ff.sq_root, 1'b0})
      else $error("square root remainder out of bound");

endmodule

`default_nettype wire

// File: rtl/core/tplp_finish.sv
// ---------------------------------------------------------------------------
// tplp_finish: back stages of the two-point line core
// Signs the quotient into the slope, multiplies slope by first x, and
// forms the intercept in the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module tplp_finish (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                advance,
   input  wire logic                                in_valid,
   input  wire tplp_pkg::tplp_iter_type             in_data,
   output logic                                     rsp_valid,
   output logic signed [tplp_pkg::SlopeW-1:0]       rsp_slope_value,
   output logic                                     rsp_vertical,
   output logic signed [tplp_pkg::SumW-1:0]         rsp_mid_x_sum,
   output logic signed [tplp_pkg::SumW-1:0]         rsp_mid_y_sum,
   output logic [tplp_pkg::SpanW-1:0]               rsp_span_length,
   output logic signed [tplp_pkg::IcptW-1:0]        rsp_y_intercept
);
   import tplp_pkg::*;

   // Stage F1: signed slope
   logic                     f1_valid_ff;
   logic signed [SlopeW-1:0] f1_slope_ff;
   logic                     f1_vert_ff;
   logic signed [SumW-1:0]   f1_midx_ff, f1_midy_ff;
   logic [SpanW-1:0]         f1_root_ff;
   logic signed [CoordW-1:0] f1_x1_ff, f1_y1_ff;

   // Stage F2: product
   logic                     f2_valid_ff;
   logic signed [ProdW-1:0]  f2_prod_ff;
   logic signed [SlopeW-1:0] f2_slope_ff;
   logic                     f2_vert_ff;
   logic signed [SumW-1:0]   f2_midx_ff, f2_midy_ff;
   logic [SpanW-1:0]         f2_root_ff;
   logic signed [CoordW-1:0] f2_y1_ff;

   // Stage F3: output register
   logic                     f3_valid_ff;
   logic signed [SlopeW-1:0] f3_slope_ff;
   logic                     f3_vert_ff;
   logic signed [SumW-1:0]   f3_midx_ff, f3_midy_ff;
   logic [SpanW-1:0]         f3_root_ff;
   logic signed [IcptW-1:0]  f3_icpt_ff;

   logic [SlopeW-1:0]        quot;
   logic signed [SlopeW-1:0] slope_in;
   logic signed [ProdW-1:0]  prod_in;
   logic signed [IcptCalcW-1:0] y1_scaled;
   logic signed [IcptCalcW-1:0] prod_shifted;
   logic signed [IcptCalcW-1:0] icpt_full;
   logic signed [IcptW-1:0]  icpt_in;

   // Apply the sign to the quotient magnitude; zero on a vertical line
   assign quot = in_data.div_acc[SlopeW-1:0];
   always_comb begin
      priority if (in_data.vertical) begin
         slope_in = '0;
      end else if (in_data.neg) begin
         slope_in = -$signed(quot);
      end else begin
         slope_in = $signed(quot);
      end
   end

   assign prod_in = ProdW'(f1_slope_ff) * ProdW'(f1_x1_ff);

   // Intercept: y1 * 256 minus floor(product / 256)
   assign y1_scaled    = IcptCalcW'($signed({f2_y1_ff, {IcptShift{1'b0}}}));
   assign prod_shifted = IcptCalcW'($signed(f2_prod_ff[ProdW-1:IcptShift]));
   assign icpt_full    = y1_scaled - prod_shifted;
   assign icpt_in      = f2_vert_ff ? '0 : icpt_full[IcptW-1:0];

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
         f3_valid_ff <= 1'b0;
      end else if (advance) begin
         f1_valid_ff <= in_valid;
         f2_valid_ff <= f1_valid_ff;
         f3_valid_ff <= f2_valid_ff;
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (advance) begin
         f1_slope_ff <= slope_in;
         f1_vert_ff  <= in_data.vertical;
         f1_midx_ff  <= in_data.mid_x;
         f1_midy_ff  <= in_data.mid_y;
         f1_root_ff  <= in_data.sq_root;
         f1_x1_ff    <= in_data.x1;
         f1_y1_ff    <= in_data.y1;

         f2_prod_ff  <= prod_in;
         f2_slope_ff <= f1_slope_ff;
         f2_vert_ff  <= f1_vert_ff;
         f2_midx_ff  <= f1_midx_ff;
         f2_midy_ff  <= f1_midy_ff;
         f2_root_ff  <= f1_root_ff;
         f2_y1_ff    <= f1_y1_ff;

         f3_slope_ff <= f2_slope_ff;
         f3_vert_ff  <= f2_vert_ff;
         f3_midx_ff  <= f2_midx_ff;
         f3_midy_ff  <= f2_midy_ff;
         f3_root_ff  <= f2_root_ff;
         f3_icpt_ff  <= icpt_in;
      end
   end

   assign rsp_valid       = f3_valid_ff;
   assign rsp_slope_value = f3_slope_ff;
   assign rsp_vertical    = f3_vert_ff;
   assign rsp_mid_x_sum   = f3_midx_ff;
   assign rsp_mid_y_sum   = f3_midy_ff;
   assign rsp_span_length = f3_root_ff;
   assign rsp_y_intercept = f3_icpt_ff;

   // A vertical line carries a zero slope set two stages earlier and a zero intercept
   a_vertical_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_vertical |-> rsp_slope_value == '0 && rsp_y_intercept == '0)
      else $error("vertical item with nonzero slope or intercept");

endmodule

`default_nettype wire

// File: rtl/core/two_point_line_properties_core.sv
// ---------------------------------------------------------------------------
// two_point_line_properties_core: slope, midpoint, length and intercept
// Pipelined line properties of two Q8.8 points: restoring divider and
// digit-by-digit square root share a chain of iteration stages.
//
//   channel | ports  | direction | content
//   --------+--------+-----------+------------------------------------------
//   input   | req_*  | in        | first_x, first_y, second_x, second_y
//   result  | rsp_*  | out       | slope_value, vertical, mid sums,
//           |        |           | span_length, y_intercept
//
// One item enters per cycle while no result is stalled at the output; each item passes through
// 3 front stages, 17 iteration stages (one root bit, two quotient bits each)
// and 3 back stages including the output register.
// Reset clears all valid bits; payload registers are not reset.
// When a result waits and rsp_ready is low, every stage holds; bubbles
// move on freely while the output register is empty or being taken.
// ---------------------------------------------------------------------------
`default_nettype none

module two_point_line_properties_core (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic signed [tplp_pkg::CoordW-1:0]   req_first_x,
   input  wire logic signed [tplp_pkg::CoordW-1:0]   req_first_y,
   input  wire logic signed [tplp_pkg::CoordW-1:0]   req_second_x,
   input  wire logic signed [tplp_pkg::CoordW-1:0]   req_second_y,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic signed [tplp_pkg::SlopeW-1:0]        rsp_slope_value,
   output logic                                      rsp_vertical,
   output logic signed [tplp_pkg::SumW-1:0]          rsp_mid_x_sum,
   output logic signed [tplp_pkg::SumW-1:0]          rsp_mid_y_sum,
   output logic [tplp_pkg::SpanW-1:0]                rsp_span_length,
   output logic signed [tplp_pkg::IcptW-1:0]         rsp_y_intercept
);
   import tplp_pkg::*;

   logic          advance;
   logic          chain_valid [IterStages+1];
   tplp_iter_type chain_data  [IterStages+1];
   logic [IterStages-1:0] iter_valid;

   // Move the whole pipe unless a finished item is stuck at the output
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   tplp_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .first_x   (req_first_x),
      .first_y   (req_first_y),
      .second_x  (req_second_x),
      .second_y  (req_second_y),
      .out_valid (chain_valid[0]),
      .out_data  (chain_data[0])
   );

   // Iteration chain
   for (genvar g = 0; g < IterStages; g++) begin : g_iter
      tplp_iter u_iter (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (chain_valid[g]),
         .in_data   (chain_data[g]),
         .out_valid (chain_valid[g+1]),
         .out_data  (chain_data[g+1])
      );
      assign iter_valid[g] = chain_valid[g+1];
   end

   tplp_finish u_finish (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .in_valid        (chain_valid[IterStages]),
      .in_data         (chain_data[IterStages]),
      .rsp_valid       (rsp_valid),
      .rsp_slope_value (rsp_slope_value),
      .rsp_vertical    (rsp_vertical),
      .rsp_mid_x_sum   (rsp_mid_x_sum),
      .rsp_mid_y_sum   (rsp_mid_y_sum),
      .rsp_span_length (rsp_span_length),
      .rsp_y_intercept (rsp_y_intercept)
   );

   // A stall freezes the occupancy of the iteration chain
   a_stall_holds_chain: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(iter_valid))
      else $error("iteration chain moved during a stall");

   // Output stall must come from a waiting result
   a_stall_has_result: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without a waiting result");

endmodule

`default_nettype wire

// File: sim/tb_two_point_line_properties_core.sv
// ---------------------------------------------------------------------------
// tb_two_point_line_properties_core: self-checking bench of the line core
// Drives point pairs through the valid/ready input channel, predicts slope,
// midpoint sums, span length and intercept of every accepted item, and
// checks each result field by field in order. Sender and receiver idle at
// random, the receiver holds off for long stretches to back the pipeline
// up, and the sender drains the core completely between phases.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_two_point_line_properties_core;

   import tplp_pkg::*;

   typedef struct {
      logic signed [CoordW-1:0] x1;
      logic signed [CoordW-1:0] y1;
      logic signed [CoordW-1:0] x2;
      logic signed [CoordW-1:0] y2;
   } point_pair_type;

   typedef struct {
      logic signed [SlopeW-1:0] slope;
      logic                     vertical;
      logic signed [SumW-1:0]   mid_x;
      logic signed [SumW-1:0]   mid_y;
      logic [SpanW-1:0]         span;
      logic signed [IcptW-1:0]  icpt;
   } line_props_type;

   localparam int LongHoldCycles = 150;
   localparam int SettleCycles   = 30;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_valid    = 1'b0;
   logic                     req_ready;
   logic signed [CoordW-1:0] req_first_x  = '0;
   logic signed [CoordW-1:0] req_first_y  = '0;
   logic signed [CoordW-1:0] req_second_x = '0;
   logic signed [CoordW-1:0] req_second_y = '0;
   logic                     rsp_valid;
   logic                     rsp_ready    = 1'b0;
   logic signed [SlopeW-1:0] rsp_slope_value;
   logic                     rsp_vertical;
   logic signed [SumW-1:0]   rsp_mid_x_sum;
   logic signed [SumW-1:0]   rsp_mid_y_sum;
   logic [SpanW-1:0]         rsp_span_length;
   logic signed [IcptW-1:0]  rsp_y_intercept;

   point_pair_type pending_pairs[$];
   line_props_type expected_props[$];
   point_pair_type offered_pair;
   point_pair_type accepted_pair;
   line_props_type arrived_want;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_request  = 0;
   int hold_taken    = 0;
   int hold_left     = 0;
   int mismatch_count = 0;

   two_point_line_properties_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_first_x     (req_first_x),
      .req_first_y     (req_first_y),
      .req_second_x    (req_second_x),
      .req_second_y    (req_second_y),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_slope_value (rsp_slope_value),
      .rsp_vertical    (rsp_vertical),
      .rsp_mid_x_sum   (rsp_mid_x_sum),
      .rsp_mid_y_sum   (rsp_mid_y_sum),
      .rsp_span_length (rsp_span_length),
      .rsp_y_intercept (rsp_y_intercept)
   );

   always #1 clock = ~clock;

   // Compute the line properties of one point pair
   function automatic line_props_type line_properties_of(point_pair_type p);
      line_props_type     r;
      longint             ax1, ay1, ax2, ay2, dx, dy, slope, icpt;
      longint unsigned    rad, root, one;
      ax1 = longint'(p.x1);
      ay1 = longint'(p.y1);
      ax2 = longint'(p.x2);
      ay2 = longint'(p.y2);
      dx = ax2 - ax1;
      dy = ay2 - ay1;
      slope = 0;
      icpt = 0;
      if (dx != 0) begin
         // divide truncates toward zero; the shift floors the Q25.24 product
         slope = (dy * 65536) / dx;
         icpt = ay1 * 256 - ((slope * ax1) >>> 8);
      end
      // floor square root, two radicand bits per step
      rad = $unsigned(dx * dx + dy * dy);
      root = 0;
      one = 64'd1 << 36;
      while (one > rad) one = one >> 2;
      while (one != 0) begin
         if (rad >= root + one) begin
            rad = rad - (root + one);
            root = (root >> 1) + one;
         end else begin
            root = root >> 1;
         end
         one = one >> 2;
      end
      r.slope    = SlopeW'(slope);
      r.vertical = (dx == 0);
      r.mid_x    = SumW'(ax1 + ax2);
      r.mid_y    = SumW'(ay1 + ay2);
      r.span     = SpanW'(root);
      r.icpt     = IcptW'(icpt);
      return r;
   endfunction

   task automatic add_pair(int x1, int y1, int x2, int y2);
      point_pair_type p;
      p.x1 = CoordW'(x1);
      p.y1 = CoordW'(y1);
      p.x2 = CoordW'(x2);
      p.y2 = CoordW'(y2);
      pending_pairs.push_back(p);
   endtask

   // Pick a coordinate among the range edges and the values around zero
   function automatic int edge_coord();
      int pick;
      pick = $urandom_range(4);
      case (pick)
         0: return -32768;
         1: return 32767;
         2: return 0;
         3: return -1;
         default: return 1;
      endcase
   endfunction

   // Queue random pairs, biased toward steep, vertical, horizontal, small and edge cases
   task automatic add_random_pairs(int count);
      int kind, x1, y1, x2, y2, d;
      for (int i = 0; i < count; i++) begin
         kind = $urandom_range(9);
         x1 = int'($signed(16'($urandom)));
         y1 = int'($signed(16'($urandom)));
         x2 = int'($signed(16'($urandom)));
         y2 = int'($signed(16'($urandom)));
         case (kind)
            4: x2 = x1;
            5: begin
               x2 = x1;
               y2 = y1;
            end
            6: begin
               d = $urandom_range(1, 4);
               x2 = (x1 > 32767 - d) ? x1 - d : x1 + d;
            end
            7: begin
               x1 = edge_coord();
               y1 = edge_coord();
               x2 = edge_coord();
               y2 = edge_coord();
            end
            8: begin
               x1 = int'($urandom_range(1024)) - 512;
               y1 = int'($urandom_range(1024)) - 512;
               x2 = int'($urandom_range(1024)) - 512;
               y2 = int'($urandom_range(1024)) - 512;
            end
            9: y2 = y1;
            default: ;
         endcase
         add_pair(x1, y1, x2, y2);
      end
   endtask

   // Wait until every queued item is accepted and every result is back
   task automatic wait_for_drain();
      while (pending_pairs.size() != 0 || req_valid || expected_props.size() != 0)
         @(negedge clock);
   endtask

   task automatic check_field(string name, logic signed [63:0] want,
                              logic signed [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // Offer queued items; hold the payload until accepted
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            accepted_pair = '{req_first_x, req_first_y, req_second_x, req_second_y};
            expected_props.push_back(line_properties_of(accepted_pair));
         end
         if (!req_valid || req_ready) begin
            if (pending_pairs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               offered_pair = pending_pairs.pop_front();
               req_valid    <= 1'b1;
               req_first_x  <= offered_pair.x1;
               req_first_y  <= offered_pair.y1;
               req_second_x <= offered_pair.x2;
               req_second_y <= offered_pair.y2;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Drive the result ready; take a long hold-off when one is requested
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (hold_taken != hold_request) begin
         hold_taken <= hold_request;
         hold_left  <= LongHoldCycles;
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Check each accepted result against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_props.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual slope %0d span %0d",
                     $time, rsp_slope_value, rsp_span_length);
            mismatch_count++;
         end else begin
            arrived_want = expected_props.pop_front();
            check_field("slope_value", arrived_want.slope, rsp_slope_value);
            check_field("vertical", {63'd0, arrived_want.vertical}, {63'd0, rsp_vertical});
            check_field("mid_x_sum", arrived_want.mid_x, rsp_mid_x_sum);
            check_field("mid_y_sum", arrived_want.mid_y, rsp_mid_y_sum);
            check_field("span_length", {47'd0, arrived_want.span}, {47'd0, rsp_span_length});
            check_field("y_intercept", arrived_want.icpt, rsp_y_intercept);
         end
      end
   end

   // Run the phases of stimulus and report
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed pairs: coincident, vertical, range edges, steepest slopes
      send_idle_pct = 29;
      recv_idle_pct = 64;
      add_pair(0, 0, 0, 0);
      add_pair(256, 512, 256, -768);
      add_pair(-32768, -32768, 32767, 32767);
      add_pair(32767, 32767, -32768, -32768);
      add_pair(0, -32768, 1, 32767);
      add_pair(0, 32767, 1, -32768);
      add_pair(-32768, 32767, 32767, -32768);
      add_pair(32767, -32768, -32768, 32767);
      add_pair(-32768, 0, 32767, 1);
      add_pair(100, 5, 300, 5);
      add_pair(-1, -1, -1, -1);
      add_pair(32767, 32767, 32767, 32767);
      add_pair(-32768, -32768, -32768, -32768);
      add_pair(3, 1, -2, 2);
      add_pair(-5, 7, 2, -3);
      add_pair(255, -256, -257, 300);
      add_pair(256, 256, 768, -256);
      add_pair(-300, 17, -299, -17);
      add_pair(-32767, 1000, -32768, -1000);
      add_pair(1, 1, -1, 2);
      add_random_pairs(220);
      while (pending_pairs.size() > 150) @(negedge clock);
      hold_request++;
      wait_for_drain();

      // Slow sender, eager receiver, held off at the start
      send_idle_pct = 64;
      recv_idle_pct = 29;
      add_random_pairs(230);
      hold_request++;
      wait_for_drain();

      // Full rate both ways; a hold-off backs the pipeline up to the input
      send_idle_pct = 0;
      recv_idle_pct = 0;
      add_random_pairs(230);
      repeat (40) @(negedge clock);
      hold_request++;
      wait_for_drain();

      repeat (SettleCycles) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("PASS two_point_line_properties_core");
      end else begin
         $display("FAIL two_point_line_properties_core");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      #400000;
      $display("FAIL two_point_line_properties_core");
      $finish;
   end

endmodule

`default_nettype wire
